/* rtl/tsel_pkg.sv */
package tsel_pkg;

  localparam logic [31:0] ExpMask    = 32'h7F80_0000;
  localparam logic [31:0] FltMaxBits = 32'h7F7F_FFFF;
  localparam logic [31:0] IdEmpty    = 32'hFFFF_FFFF;
  localparam int unsigned KeepW      = 7;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_KEEP    = 3'd1,
    REG_THR_EN  = 3'd2,
    REG_THR     = 3'd3,
    REG_REORDER = 3'd4,
    REG_RADIUS  = 3'd5
  } reg_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] distance;
    logic [31:0] id;
    logic        allowed;
  } cmd_t;

  typedef struct packed {
    logic             mode;
    logic [KeepW-1:0] keep;
    logic             thr_en;
    logic [31:0]      thr;
    logic             reorder;
    logic [31:0]      radius;
  } cfg_t;

  function automatic logic f_isnan(input logic [31:0] b);
    f_isnan = ((b & ExpMask) == ExpMask) && (b[22:0] != 23'd0);
  endfunction

  // map to an unsigned key that orders like the float value
  function automatic logic [31:0] f_key(input logic [31:0] b);
    f_key = b[31] ? ~b : (b | 32'h8000_0000);
  endfunction

  function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
    logic zz;
    zz = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    f_le = !f_isnan(a) && !f_isnan(b) && (zz || (f_key(a) <= f_key(b)));
  endfunction

  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic zz;
    zz = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    f_lt = !f_isnan(a) && !f_isnan(b) && !zz && (f_key(a) < f_key(b));
  endfunction

endpackage

/* rtl/tsel_front.sv */
module tsel_front
  import tsel_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output cmd_t q_cmd_o
);

  cmd_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  // unused op codes are dropped here
  assign push       = in_valid_i && in_ready_o && (in_cmd_i.op != OP_NONE);
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_cmd_i;
  end

endmodule

/* rtl/tsel_back.sv */
module tsel_back
  import tsel_pkg::*;
#(
  parameter int unsigned MaxKeep = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  cmd_t        q_cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_dist_o,
  output logic [31:0] out_id_o,
  output logic        out_present_o,
  output logic        out_last_o
);

  localparam int unsigned FillW = $clog2(MaxKeep + 1);
  localparam int unsigned IdxW  = (MaxKeep > 1) ? $clog2(MaxKeep) : 1;
  localparam logic [FillW-1:0] MaxFill = FillW'(MaxKeep);

  logic [31:0]      dist_q [MaxKeep];
  logic [31:0]      id_q   [MaxKeep];
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] rd_q, rd_d;
  logic             ov_q;
  logic [31:0]      od_q, oi_q;
  logic             op_q, ol_q;

  logic [MaxKeep-1:0] prec, below;
  logic [FillW-1:0]   keff, fill_ins, top_idx;
  logic               full, lt_top, skip, ins_ok, do_ins, load_ok, is_last;
  logic [31:0]        d;

  assign d = q_cmd_i.distance;

  always_comb begin
    if (cfg_i.keep == '0) keff = FillW'(1);
    else if ({{(32-KeepW){1'b0}}, cfg_i.keep} > MaxKeep) keff = MaxFill;
    else keff = FillW'(cfg_i.keep);
  end

  always_comb begin
    for (int i = 0; i < MaxKeep; i++) begin
      prec[i]  = (f_isnan(d) || (!f_isnan(dist_q[i]) && f_le(dist_q[i], d)))
                 && (FillW'(i) < fill_q);
      below[i] = f_lt(d, dist_q[i]);
    end
  end

  assign full    = (fill_q >= keff);
  assign top_idx = fill_q - FillW'(1);
  assign lt_top  = full ? below[top_idx[IdxW-1:0]] : f_lt(d, FltMaxBits);

  always_comb begin
    skip = (q_cmd_i.id == IdEmpty) || !q_cmd_i.allowed;
    if (!cfg_i.mode) begin
      if (cfg_i.thr_en && (((d & ExpMask) == ExpMask) ||
          (!cfg_i.reorder && f_lt(cfg_i.thr, d)))) skip = 1'b1;
      ins_ok = !full || lt_top;
    end else begin
      ins_ok = f_le(d, cfg_i.radius) && lt_top;
    end
  end

  assign load_ok = !ov_q || out_ready_i;
  assign is_last = (fill_q == '0) || (rd_q == fill_q - FillW'(1));

  always_comb begin
    q_pop_o  = 1'b0;
    do_ins   = 1'b0;
    fill_ins = fill_q;
    fill_d   = fill_q;
    rd_d     = rd_q;
    if (q_valid_i) begin
      case (q_cmd_i.op)
        OP_OFFER: begin
          q_pop_o = 1'b1;
          if (!skip) begin
            do_ins   = ins_ok && !prec[MaxKeep-1];
            fill_ins = do_ins ? ((fill_q < MaxFill) ? fill_q : MaxFill - FillW'(1))
                                + FillW'(1) : fill_q;
            fill_d   = (fill_ins > keff) ? keff : fill_ins;
          end
        end
        OP_CLEAR: begin
          q_pop_o = 1'b1;
          fill_d  = '0;
        end
        OP_READ: begin
          if (load_ok) begin
            q_pop_o = is_last;
            rd_d    = is_last ? '0 : rd_q + FillW'(1);
          end
        end
        default: q_pop_o = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rd_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rd_q   <= rd_d;
      if (load_ok) ov_q <= q_valid_i && (q_cmd_i.op == OP_READ);
    end
  end

  // shift the tail up by one from the insertion point
  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      for (int i = 0; i < MaxKeep; i++) begin
        if (!prec[i]) begin
          if (i == 0 || prec[(i == 0) ? 0 : i-1]) begin
            dist_q[i] <= d;
            id_q[i]   <= q_cmd_i.id;
          end else begin
            dist_q[i] <= dist_q[(i == 0) ? 0 : i-1];
            id_q[i]   <= id_q[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && q_valid_i && (q_cmd_i.op == OP_READ)) begin
      op_q <= (fill_q != '0);
      ol_q <= is_last;
      od_q <= (fill_q != '0) ? dist_q[rd_q[IdxW-1:0]] : 32'd0;
      oi_q <= (fill_q != '0) ? id_q[rd_q[IdxW-1:0]] : 32'd0;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_dist_o    = od_q;
  assign out_id_o      = oi_q;
  assign out_present_o = op_q;
  assign out_last_o    = ol_q;

endmodule

/* rtl/topk_candidate_selector.sv */
// Top-k candidate selector.
// Candidates, clears and readouts arrive as beats on the s_axis channel
// (tuser = op). An offer or clear beat is taken by the back end at once;
// the front end queues up to two beats so input keeps flowing while the
// back end is busy. A readout emits one m_axis beat per kept entry in
// ascending distance order (one beat with the valid flag low if the set is
// empty), tlast on the final beat; it occupies the back end until its last
// entry is loaded, one entry per cycle from the insertion chain's readout
// port unless m_axis_tready stalls. A readout beat passes the front-end
// queue and the output register before its first result beat is shown.
// An offer updates the sorted chain of MAX_KEEP cells. Registers are
// written by the user on the cfg channel (always ready) while idle; the
// block does not enforce it. Reset empties the kept set and the queue
// and restores register defaults. A stall on m_axis_tready holds the output
// register and the readout; the queue then fills and s_axis_tready drops.
module topk_candidate_selector
  import tsel_pkg::*;
#(
  parameter int unsigned MAX_KEEP = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // cand_distance, cand_id, cand_allowed
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_distance, out_id, out_valid
  output logic        m_axis_tlast,   // out_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t        cfg_q;
  cmd_t        in_cmd, q_cmd;
  logic        q_valid, q_pop;
  logic [31:0] o_dist, o_id;
  logic        o_pres;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: 1'b0, keep: KeepW'(10), thr_en: 1'b0, thr: 32'd0,
                 reorder: 1'b0, radius: 32'd0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:    cfg_q.mode    <= cfg_data_i[0];
        REG_KEEP:    cfg_q.keep    <= cfg_data_i[KeepW-1:0];
        REG_THR_EN:  cfg_q.thr_en  <= cfg_data_i[0];
        REG_THR:     cfg_q.thr     <= cfg_data_i;
        REG_REORDER: cfg_q.reorder <= cfg_data_i[0];
        REG_RADIUS:  cfg_q.radius  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_cmd.op       = op_e'(s_axis_tuser);
  assign in_cmd.distance = s_axis_tdata[31:0];
  assign in_cmd.id       = s_axis_tdata[63:32];
  assign in_cmd.allowed  = s_axis_tdata[64];

  tsel_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (in_cmd),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_cmd_o    (q_cmd)
  );

  tsel_back #(.MaxKeep(MAX_KEEP)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_cmd_i       (q_cmd),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_dist_o    (o_dist),
    .out_id_o      (o_id),
    .out_present_o (o_pres),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, o_pres, o_id, o_dist};

endmodule

/* tb/topk_candidate_selector_test.sv */
`timescale 1ns / 100ps

module topk_candidate_selector_test;
  import tsel_pkg::*;

  localparam int MaxKeep   = 64;
  localparam int CycleCap  = 400000;
  localparam int RandItems = 110;

  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] id;
    logic        present;
    logic        last;
  } entry_t;

  // one row of the directed table; chk_first: compare first readout beat to row value
  typedef struct {
    op_e         op;
    logic [31:0] distance;
    logic [31:0] id;
    logic        allowed;
    logic        chk_first;
    entry_t      first;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  topk_candidate_selector dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic        mode_q, thr_en_q, reorder_q;
  logic [6:0]  keep_q;
  logic [31:0] thr_q, radius_q;
  logic [31:0] kept_dist[MaxKeep];
  logic [31:0] kept_id[MaxKeep];
  int          kept_n;

  entry_t readout_q[$];
  int     n_err, n_beats, n_reads, n_offers, cycles;
  bit     pinned_pending;
  entry_t pinned_val;

  task automatic report(input string what);
    n_err++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic bit is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 0);
  endfunction

  // IEEE order on bit patterns, NaN comparing false
  function automatic bit flt_lt(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 0;
    if (a[30:0] == 0 && b[30:0] == 0) return 0;
    if (a[31] != b[31]) return a[31];
    if (a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  function automatic bit flt_le(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 0;
    return !flt_lt(b, a);
  endfunction

  function automatic int keep_eff();
    if (keep_q == 0) return 1;
    if (keep_q > MaxKeep) return MaxKeep;
    return keep_q;
  endfunction

  function automatic void place(input logic [31:0] d, input logic [31:0] id);
    int p, top;
    p = 0;
    while (p < kept_n &&
           (is_nan(d) || (!is_nan(kept_dist[p]) && flt_le(kept_dist[p], d)))) p++;
    top = (kept_n < MaxKeep) ? kept_n : MaxKeep - 1;
    if (p > top) return;
    for (int i = top; i > p; i--) begin
      kept_dist[i] = kept_dist[i-1];
      kept_id[i] = kept_id[i-1];
    end
    kept_dist[p] = d;
    kept_id[p] = id;
    kept_n = top + 1;
  endfunction

  function automatic void predict(input op_e op, input logic [31:0] d,
                                  input logic [31:0] id, input logic ok);
    int k;
    bit full;
    logic [31:0] top;
    entry_t e;
    k = keep_eff();
    case (op)
      OP_OFFER: begin
        full = kept_n >= k;
        top = full ? kept_dist[kept_n-1] : FltMaxBits;
        if (id == IdEmpty || !ok) return;
        if (!mode_q) begin
          if (thr_en_q && d[30:23] == 8'hFF) return;
          if (thr_en_q && !reorder_q && flt_lt(thr_q, d)) return;
          if (!full || flt_lt(d, top)) place(d, id);
        end else if (flt_le(d, radius_q) && flt_lt(d, top)) begin
          place(d, id);
        end
        if (kept_n > k) kept_n = k;
      end
      OP_CLEAR: kept_n = 0;
      OP_READ: begin
        if (kept_n == 0) begin
          e = '{distance: '0, id: '0, present: 1'b0, last: 1'b1};
          readout_q.push_back(e);
        end
        for (int i = 0; i < kept_n; i++) begin
          e = '{distance: kept_dist[i], id: kept_id[i], present: 1'b1,
                last: (i == kept_n - 1)};
          readout_q.push_back(e);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic write_reg(input reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MODE:    mode_q = val[0];
      REG_KEEP:    keep_q = val[6:0];
      REG_THR_EN:  thr_en_q = val[0];
      REG_THR:     thr_q = val;
      REG_REORDER: reorder_q = val[0];
      REG_RADIUS:  radius_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // drive one beat, with a random gap in front on burst boundaries
  int burst_left = 0;
  task automatic send(input op_e op, input logic [31:0] d, input logic [31:0] id,
                      input logic ok);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, ok, id, d};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(op, d, id, ok);
    if (op == OP_OFFER) n_offers++;
    if (op == OP_READ) n_reads++;
  endtask

  task automatic send_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: m_axis_tready <= (cycles % 5) < 2;
    endcase
  end

  always @(posedge clk_i) begin
    entry_t got, want;
    cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{distance: m_axis_tdata[31:0], id: m_axis_tdata[63:32],
              present: m_axis_tdata[64], last: m_axis_tlast};
      n_beats++;
      if (readout_q.size() == 0) begin
        report($sformatf("unexpected result beat %h", got));
      end else begin
        want = readout_q.pop_front();
        if (pinned_pending) begin
          pinned_pending = 0;
          if (got != pinned_val) report($sformatf("table value %h got %h", pinned_val, got));
        end
        if (got.distance != want.distance)
          report($sformatf("distance %h want %h", got.distance, want.distance));
        if (got.id != want.id) report($sformatf("id %h want %h", got.id, want.id));
        if (got.present != want.present) report("valid flag wrong");
        if (got.last != want.last) report("last flag wrong");
      end
    end
    if (cycles > CycleCap) begin
      $display("topk_candidate_selector_test: errors");
      $finish;
    end
  end

  // distances picked to hit ties, zeros, infinities and NaNs
  function automatic logic [31:0] pick_dist();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'h7FC0_0000 | $urandom_range(0, 255);
      4: return 32'hFF80_0000;
      5: return $urandom();
      default: return {1'b0, 8'd127, 23'($urandom_range(0, 7)) << 20};
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
        send(OP_OFFER, pick_dist(),
             ($urandom_range(0, 15) == 0) ? IdEmpty : $urandom(),
             $urandom_range(0, 5) != 0);
      else if (r < 88) send(OP_READ, $urandom(), $urandom(), $urandom_range(0, 1));
      else if (r < 94) send(OP_CLEAR, $urandom(), $urandom(), $urandom_range(0, 1));
      else send(OP_NONE, $urandom(), $urandom(), $urandom_range(0, 1));
    end
    send_idle();
  endtask

  row_t table_rows[] = '{
    '{OP_READ,  32'h0, 32'h0, 1'b0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}},
    '{OP_OFFER, 32'h3F80_0000, 32'd1, 1'b1, 1'b0, '0},
    '{OP_OFFER, 32'h8000_0000, 32'd2, 1'b1, 1'b0, '0},
    '{OP_OFFER, 32'h0000_0000, 32'd3, 1'b1, 1'b0, '0},
    '{OP_OFFER, 32'h7FC0_0001, 32'd4, 1'b1, 1'b0, '0},
    '{OP_OFFER, 32'h7F80_0000, 32'd5, 1'b1, 1'b0, '0},
    '{OP_OFFER, 32'hFF80_0000, 32'd6, 1'b1, 1'b0, '0},
    '{OP_OFFER, 32'h4000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{OP_OFFER, 32'h4000_0000, 32'd7, 1'b0, 1'b0, '0},
    '{OP_OFFER, 32'hFFFF_FFFF, 32'd8, 1'b1, 1'b0, '0},
    '{OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{OP_READ,  32'h0, 32'h0, 1'b0, 1'b1, '{32'hFF80_0000, 32'd6, 1'b1, 1'b0}},
    '{OP_CLEAR, 32'h0, 32'h0, 1'b0, 1'b0, '0},
    '{OP_READ,  32'h0, 32'h0, 1'b0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}}
  };

  task automatic run_table();
    foreach (table_rows[i]) begin
      if (table_rows[i].chk_first) begin
        // let earlier readouts leave so the pinned value meets its own beat
        send_idle();
        while (readout_q.size() != 0) @(posedge clk_i);
        pinned_pending = 1;
        pinned_val = table_rows[i].first;
      end
      send(table_rows[i].op, table_rows[i].distance, table_rows[i].id,
           table_rows[i].allowed);
    end
    send_idle();
  endtask

  initial begin
    mode_q = 0; keep_q = 7'd10; thr_en_q = 0; thr_q = 0; reorder_q = 0; radius_q = 0;
    kept_n = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_table();
    drain();

    // nearest mode, small k so eviction and trimming happen
    write_reg(REG_KEEP, 32'd3);
    random_phase(9);
    drain();
    write_reg(REG_THR_EN, 32'd1);
    write_reg(REG_THR, 32'h3FC0_0000);
    random_phase(6);
    drain();
    write_reg(REG_REORDER, 32'd1);
    write_reg(REG_KEEP, 32'd0);
    random_phase(5);
    drain();
    // range mode, keep count above the cap
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_RADIUS, 32'h3FF0_0000);
    write_reg(REG_KEEP, 32'd127);
    random_phase(6);
    drain();
    write_reg(REG_KEEP, 32'd2);
    write_reg(REG_RADIUS, 32'h7F80_0000);
    random_phase(5);
    drain();
    // nearest again at full depth, more offers than the set can keep
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_THR_EN, 32'd0);
    write_reg(REG_KEEP, 32'd64);
    for (int i = 0; i < 66; i++) send(OP_OFFER, $urandom(), $urandom(), 1'b1);
    send(OP_READ, 32'h0, 32'h0, 1'b0);
    send_idle();
    drain();

    $display("covered %0d offers and %0d readouts, %0d result beats checked",
             n_offers, n_reads, n_beats);
    if (n_err == 0)
      $display("topk_candidate_selector_test: clean");
    else
      $display("topk_candidate_selector_test: errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/tsel_pkg.sv
rtl/tsel_front.sv
rtl/tsel_back.sv
rtl/topk_candidate_selector.sv
tb/topk_candidate_selector_test.sv
